@@ hw/rtl/best_fit_region_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit region allocator
// Shared implication checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bfra_pkg.sv @@
// ----------------------------------------------------------------------------
// bfra_pkg
// Types and codes shared by the region allocator controller and datapath.
// ----------------------------------------------------------------------------
package bfra_pkg;

    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 7;
    localparam int STAT_W    = 32;
    localparam int CFG_W     = 16;

    localparam logic [CFG_W-1:0] TOTAL_SIZE_RESET = 16'd1024;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd6;

    // table sweeps run by the datapath
    typedef enum logic [2:0] {
        SW_FIND,
        SW_MATCH,
        SW_COMPACT,
        SW_SHIFT,
        SW_STATS
    } sweep_t;

    typedef struct packed {
        logic                latch;
        logic                init;
        logic                sweep_start;
        logic                sweep_run;
        sweep_t              kind;
        logic                commit;
        logic                insert;
        logic                flush;
        logic                count_success;
        logic                count_fail;
        logic                load_result;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic req_zero;
        logic found;
        logic exact_fit;
        logic table_full;
        logic job_found;
        logic out_free;
    } dp_stat_t;

endpackage

@@ hw/rtl/bfra_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfra_ctrl
// Command sequencer: orders the table sweeps and picks the result status.
// ----------------------------------------------------------------------------
module bfra_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic [bfra_pkg::CMD_W-1:0] command,
    output logic                    s_tready,
    output bfra_pkg::dp_cmd_t       cmd,
    input  bfra_pkg::dp_stat_t      stat
);
    import bfra_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FIND,
        S_ALLOC_DECIDE,
        S_SHIFT,
        S_INSERT,
        S_COMMIT,
        S_MATCH,
        S_MATCH_DECIDE,
        S_COMPACT,
        S_FLUSH,
        S_STATS,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.kind    = SW_STATS;
        cmd.status  = status_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch       = 1'b1;
                    cmd.sweep_start = 1'b1;
                    case (command)
                        CMD_ALLOC:
                        begin
                            cmd.kind   = SW_FIND;
                            state_next = S_FIND;
                        end
                        CMD_RELEASE:
                        begin
                            cmd.kind   = SW_MATCH;
                            state_next = S_MATCH;
                        end
                        CMD_RESET:
                        begin
                            cmd.init    = 1'b1;
                            status_next = ST_DONE;
                            state_next  = S_STATS;
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                            state_next  = S_STATS;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                cmd.kind      = SW_FIND;
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = S_ALLOC_DECIDE;
            end
            S_ALLOC_DECIDE:
            begin
                if (stat.req_zero)
                begin
                    status_next     = ST_INVALID;
                    cmd.sweep_start = 1'b1;
                    state_next      = S_STATS;
                end
                else if (!stat.found)
                begin
                    status_next     = ST_NO_FIT;
                    cmd.count_fail  = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = S_STATS;
                end
                else if (!stat.exact_fit && stat.table_full)
                begin
                    status_next     = ST_TABLE_FULL;
                    cmd.count_fail  = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = S_STATS;
                end
                else
                begin
                    status_next       = ST_ALLOCATED;
                    cmd.count_success = 1'b1;
                    if (stat.exact_fit)
                        state_next = S_COMMIT;
                    else
                    begin
                        cmd.kind        = SW_SHIFT;
                        cmd.sweep_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.kind      = SW_SHIFT;
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit      = 1'b1;
                cmd.sweep_start = 1'b1;
                state_next      = S_STATS;
            end
            S_MATCH:
            begin
                cmd.kind      = SW_MATCH;
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = S_MATCH_DECIDE;
            end
            S_MATCH_DECIDE:
            begin
                cmd.sweep_start = 1'b1;
                if (stat.job_found)
                begin
                    status_next = ST_RELEASED;
                    cmd.kind    = SW_COMPACT;
                    state_next  = S_COMPACT;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_STATS;
                end
            end
            S_COMPACT:
            begin
                cmd.kind      = SW_COMPACT;
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                cmd.flush       = 1'b1;
                cmd.sweep_start = 1'b1;
                state_next      = S_STATS;
            end
            S_STATS:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ hw/rtl/bfra_dpath.sv @@
// ----------------------------------------------------------------------------
// bfra_dpath
// Region table memories, sweep engine, accumulators and result register.
// ----------------------------------------------------------------------------
module bfra_dpath
#(
    parameter int MAX_REGIONS = 64,
    parameter int SIZE_BITS   = 16,
    parameter int JOB_BITS    = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bfra_pkg::dp_cmd_t                  cmd,
    output bfra_pkg::dp_stat_t                 stat,
    input  logic                               cfg_wr_en,
    input  logic [bfra_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic [SIZE_BITS-1:0]               in_request_size,
    input  logic [JOB_BITS-1:0]                in_job_id,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [bfra_pkg::STATUS_W-1:0]      status,
    output logic [SIZE_BITS-1:0]               base_address,
    output logic [SIZE_BITS-1:0]               free_total,
    output logic [SIZE_BITS-1:0]               used_total,
    output logic [bfra_pkg::CNT_OUT_W-1:0]     free_regions,
    output logic [bfra_pkg::CNT_OUT_W-1:0]     used_regions,
    output logic [SIZE_BITS-1:0]               largest_free,
    output logic [bfra_pkg::STAT_W-1:0]        success_count,
    output logic [bfra_pkg::STAT_W-1:0]        failure_count
);
    import bfra_pkg::*;

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);

    // region table
    logic [SIZE_BITS-1:0] base_mem  [MAX_REGIONS];
    logic [SIZE_BITS-1:0] size_mem  [MAX_REGIONS];
    logic                 free_mem  [MAX_REGIONS];
    logic [JOB_BITS-1:0]  owner_mem [MAX_REGIONS];

    logic [SIZE_BITS-1:0] rd_base_reg, rd_size_reg;
    logic                 rd_free_reg;
    logic [JOB_BITS-1:0]  rd_owner_reg;

    logic [CFG_W-1:0]     total_size_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        ptr_reg;
    logic                 pipe_v_reg;
    logic [IW-1:0]        pipe_idx_reg;
    logic                 found_reg, job_found_reg, pend_v_reg;
    logic [IW-1:0]        best_idx_reg, wr_ptr_reg;
    logic [STAT_W-1:0]    success_reg, failure_reg;
    logic                 m_valid_reg;

    logic [SIZE_BITS-1:0] req_reg, best_size_reg, best_base_reg, base_out_reg;
    logic [JOB_BITS-1:0]  job_reg;
    logic [SIZE_BITS-1:0] pend_base_reg, pend_size_reg;
    logic                 pend_free_reg;
    logic [JOB_BITS-1:0]  pend_owner_reg;
    logic [SIZE_BITS-1:0] free_sum_reg, used_sum_reg, largest_reg;
    logic [CNT_OUT_W-1:0] nfree_reg, nused_reg;

    logic                 more, issue, e_free, merge, better;
    logic [IW-1:0]        rd_addr;
    logic [CW-1:0]        best_plus1;
    logic                 we;
    logic [IW-1:0]        wa;
    logic [SIZE_BITS-1:0] wbase, wsize;
    logic                 wfree;
    logic [JOB_BITS-1:0]  wowner;

    // sweep address generation
    assign best_plus1 = CW'(best_idx_reg) + CW'(1);
    always_comb
    begin
        if (cmd.kind == SW_SHIFT)
        begin
            more    = (ptr_reg > best_plus1);
            rd_addr = IW'(ptr_reg - CW'(1));
        end
        else
        begin
            more    = (ptr_reg < count_reg);
            rd_addr = ptr_reg[IW-1:0];
        end
    end
    assign issue = cmd.sweep_run && more;

    // element coming back from the table
    assign e_free = rd_free_reg || (rd_owner_reg == job_reg);
    assign merge  = pend_free_reg && e_free;
    assign better = rd_free_reg && (rd_size_reg >= req_reg)
                    && (!found_reg || (rd_size_reg < best_size_reg));

    // single write port
    always_comb
    begin
        we     = 1'b0;
        wa     = '0;
        wbase  = '0;
        wsize  = '0;
        wfree  = 1'b0;
        wowner = '0;
        if (cmd.init)
        begin
            we    = 1'b1;
            wsize = SIZE_BITS'(total_size_reg);
            wfree = 1'b1;
        end
        else if (cmd.commit)
        begin
            we     = 1'b1;
            wa     = best_idx_reg;
            wbase  = best_base_reg;
            wsize  = req_reg;
            wowner = job_reg;
        end
        else if (cmd.insert)
        begin
            we    = 1'b1;
            wa    = IW'(best_plus1);
            wbase = best_base_reg + req_reg;
            wsize = best_size_reg - req_reg;
            wfree = 1'b1;
        end
        else if (cmd.flush)
        begin
            we     = 1'b1;
            wa     = wr_ptr_reg;
            wbase  = pend_base_reg;
            wsize  = pend_size_reg;
            wfree  = pend_free_reg;
            wowner = pend_owner_reg;
        end
        else if (cmd.sweep_run && pipe_v_reg)
        begin
            if (cmd.kind == SW_SHIFT)
            begin
                we     = 1'b1;
                wa     = IW'(pipe_idx_reg + 1'b1);
                wbase  = rd_base_reg;
                wsize  = rd_size_reg;
                wfree  = rd_free_reg;
                wowner = rd_owner_reg;
            end
            else if (cmd.kind == SW_COMPACT && pend_v_reg && !merge)
            begin
                we     = 1'b1;
                wa     = wr_ptr_reg;
                wbase  = pend_base_reg;
                wsize  = pend_size_reg;
                wfree  = pend_free_reg;
                wowner = pend_owner_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            base_mem[wa]  <= wbase;
            size_mem[wa]  <= wsize;
            free_mem[wa]  <= wfree;
            owner_mem[wa] <= wowner;
        end
        if (issue)
        begin
            rd_base_reg  <= base_mem[rd_addr];
            rd_size_reg  <= size_mem[rd_addr];
            rd_free_reg  <= free_mem[rd_addr];
            rd_owner_reg <= owner_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg <= TOTAL_SIZE_RESET;
            count_reg      <= CW'(1);
            ptr_reg        <= '0;
            pipe_v_reg     <= 1'b0;
            pipe_idx_reg   <= '0;
            found_reg      <= 1'b0;
            job_found_reg  <= 1'b0;
            pend_v_reg     <= 1'b0;
            best_idx_reg   <= '0;
            wr_ptr_reg     <= '0;
            success_reg    <= '0;
            failure_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                total_size_reg <= cfg_wr_data;
            if (cmd.init)
            begin
                count_reg   <= CW'(1);
                success_reg <= '0;
                failure_reg <= '0;
            end
            if (cmd.count_success)
                success_reg <= success_reg + 1'b1;
            if (cmd.count_fail)
                failure_reg <= failure_reg + 1'b1;
            if (cmd.insert)
                count_reg <= count_reg + 1'b1;
            if (cmd.flush)
                count_reg <= CW'(wr_ptr_reg) + CW'(1);

            if (cmd.sweep_start)
            begin
                ptr_reg       <= (cmd.kind == SW_SHIFT) ? count_reg : '0;
                pipe_v_reg    <= 1'b0;
                job_found_reg <= 1'b0;
                pend_v_reg    <= 1'b0;
                wr_ptr_reg    <= '0;
                // shift and compact keep the find result
                if (!(cmd.kind inside {SW_SHIFT, SW_COMPACT}))
                    found_reg <= 1'b0;
            end
            else if (cmd.sweep_run)
            begin
                pipe_v_reg <= issue;
                if (issue)
                begin
                    pipe_idx_reg <= rd_addr;
                    ptr_reg      <= (cmd.kind == SW_SHIFT) ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                end
                if (pipe_v_reg)
                begin
                    case (cmd.kind)
                        SW_FIND:
                        begin
                            if (better)
                            begin
                                found_reg    <= 1'b1;
                                best_idx_reg <= pipe_idx_reg;
                            end
                        end
                        SW_MATCH:
                        begin
                            if (!rd_free_reg && rd_owner_reg == job_reg)
                                job_found_reg <= 1'b1;
                        end
                        SW_COMPACT:
                        begin
                            pend_v_reg <= 1'b1;
                            if (pend_v_reg && !merge)
                                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (cmd.load_result)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg      <= in_request_size;
            job_reg      <= in_job_id;
            base_out_reg <= '0;
        end
        if (cmd.commit)
            base_out_reg <= best_base_reg;
        if (cmd.sweep_start)
        begin
            free_sum_reg <= '0;
            used_sum_reg <= '0;
            largest_reg  <= '0;
            nfree_reg    <= '0;
            nused_reg    <= '0;
        end
        else if (cmd.sweep_run && pipe_v_reg)
        begin
            case (cmd.kind)
                SW_FIND:
                begin
                    if (better)
                    begin
                        best_size_reg <= rd_size_reg;
                        best_base_reg <= rd_base_reg;
                    end
                end
                SW_COMPACT:
                begin
                    if (pend_v_reg && merge)
                        pend_size_reg <= pend_size_reg + rd_size_reg;
                    else
                    begin
                        pend_base_reg  <= rd_base_reg;
                        pend_size_reg  <= rd_size_reg;
                        pend_free_reg  <= e_free;
                        pend_owner_reg <= rd_owner_reg;
                    end
                end
                SW_STATS:
                begin
                    if (rd_free_reg)
                    begin
                        free_sum_reg <= free_sum_reg + rd_size_reg;
                        nfree_reg    <= nfree_reg + 1'b1;
                        if (rd_size_reg > largest_reg)
                            largest_reg <= rd_size_reg;
                    end
                    else
                    begin
                        used_sum_reg <= used_sum_reg + rd_size_reg;
                        nused_reg    <= nused_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load_result)
        begin
            status        <= cmd.status;
            base_address  <= base_out_reg;
            free_total    <= free_sum_reg;
            used_total    <= used_sum_reg;
            free_regions  <= nfree_reg;
            used_regions  <= nused_reg;
            largest_free  <= largest_reg;
            success_count <= success_reg;
            failure_count <= failure_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    assign stat.sweep_done = !more && !pipe_v_reg;
    assign stat.req_zero   = (req_reg == '0);
    assign stat.found      = found_reg;
    assign stat.exact_fit  = (best_size_reg == req_reg);
    assign stat.table_full = (count_reg >= CW'(MAX_REGIONS));
    assign stat.job_found  = job_found_reg;
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule

@@ hw/rtl/best_fit_region_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_region_allocator
// Best-fit allocator over an address-ordered region table, with coalescing.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tuser: command; tdata: request, job
//  m_*       out        m_tvalid/m_tready   tuser: status;  tdata: base, stats
//  cfg_*     in         cfg_wr_en           total_size (16 bits)
//
//  Sweeps per command: allocate runs the find and statistics sweeps, plus a shift
//  sweep with a split; release runs the match, compact and statistics sweeps, or
//  match and statistics if the job owns nothing; query and reset run a statistics
//  sweep. Each sweep is paced by the one table read port.
//  After rst_n is released the S_INIT state writes the single free region; s_tready is low.
//  A waiting result does not block the input; only the next result stalls on m_tready.
//
`include "best_fit_region_allocator_assert.svh"

module best_fit_region_allocator
#(
    parameter int MAX_REGIONS = 64,
    parameter int SIZE_BITS   = 16,
    parameter int JOB_BITS    = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // request_size, job_id
    input  logic [((SIZE_BITS+JOB_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  logic [bfra_pkg::CMD_W-1:0]              s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // base_address, free_total, used_total, free_regions, used_regions,
    // largest_free, success_count, failure_count
    output logic [((4*SIZE_BITS+2*bfra_pkg::CNT_OUT_W+2*bfra_pkg::STAT_W+7)/8)*8-1:0] m_tdata,
    // status
    output logic [bfra_pkg::STATUS_W-1:0]           m_tuser,
    input  logic                                   cfg_wr_en,
    input  logic [bfra_pkg::CFG_W-1:0]              cfg_wr_data
);
    import bfra_pkg::*;

    localparam int OUT_USED = 4*SIZE_BITS + 2*CNT_OUT_W + 2*STAT_W;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [SIZE_BITS-1:0] base_address, free_total, used_total, largest_free;
    logic [CNT_OUT_W-1:0] free_regions, used_regions;
    logic [STAT_W-1:0]    success_count, failure_count;

    // sequencer
    bfra_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .command  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // table, sweeps and output register
    bfra_dpath
    #(
        .MAX_REGIONS (MAX_REGIONS),
        .SIZE_BITS   (SIZE_BITS),
        .JOB_BITS    (JOB_BITS)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_request_size (s_tdata[SIZE_BITS-1:0]),
        .in_job_id       (s_tdata[SIZE_BITS+JOB_BITS-1:SIZE_BITS]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .status          (m_tuser),
        .base_address    (base_address),
        .free_total      (free_total),
        .used_total      (used_total),
        .free_regions    (free_regions),
        .used_regions    (used_regions),
        .largest_free    (largest_free),
        .success_count   (success_count),
        .failure_count   (failure_count)
    );

    // pack result, lowest field first, zero pad to bytes
    assign m_tdata = OUT_W'({failure_count, success_count, largest_free, used_regions,
                             free_regions, used_total, free_total, base_address});

    // one command in flight: taking a transfer closes the input side
    `BFRA_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second command taken while busy")
    `BFRA_ASSERT_IMP(a_status_code, m_tvalid, m_tuser != 3'd7, "result status code out of range")
    `BFRA_ASSERT_IMP(a_base_zero, m_tvalid && (m_tuser != ST_ALLOCATED), base_address == '0, "base set on a non-allocating result")

endmodule
